[src/rprt_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rprt_pkg
// Shared types and constants of the reliable packet retransmit table.
// -----------------------------------------------------------------------------
package rprt_pkg;

   localparam int ENTRIES_DEF = 32;
   localparam int ID_BITS_DEF = 32;

   localparam int FD_W   = 8;
   localparam int RI_W   = 8;
   localparam int LIFE_W = 12;
   localparam int AGE_W  = 13;
   localparam int CD_W   = 8;
   localparam int CSR_W  = 12;

   localparam logic [AGE_W-1:0]  AGE_MAX        = {AGE_W{1'b1}};
   localparam logic [FD_W-1:0]   FD_RESET       = 8'd5;
   localparam logic [RI_W-1:0]   RI_RESET       = 8'd10;
   localparam logic [LIFE_W-1:0] LIFE_RESET     = 12'd600;

   typedef enum logic [1:0] {
      REQ_SEND = 2'd0,
      REQ_ACK  = 2'd1,
      REQ_DATA = 2'd2,
      REQ_TICK = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_STORED    = 3'd0,
      EV_FULL      = 3'd1,
      EV_RESEND    = 3'd2,
      EV_EXPIRED   = 3'd3,
      EV_ACK_MATCH = 3'd4,
      EV_ACK_MISS  = 3'd5,
      EV_SEND_ACK  = 3'd6,
      EV_TICK_DONE = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      CSR_FIRST_DELAY     = 2'd0,
      CSR_RESEND_INTERVAL = 2'd1,
      CSR_LIFETIME        = 2'd2
   } csr_index_type;

endpackage

[src/reliable_packet_retransmit_table.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// reliable_packet_retransmit_table
// Table of unacknowledged packet ids with per-entry resend and expiry timers.
// -----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | req_type, req_packet_id
//  rsp     | out | rsp_valid/rsp_ready | rsp_event_res, rsp_result_id, rsp_resent, rsp_last
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_wdata
//
//  Send and data items need no table walk; ack and tick items walk all n live
//  entries, one table entry per cycle through the single memory read port unless stalled.
//  Entries live in a circular memory, newest at the head; ack and tick compact
//  the table in the same pass. Reset clears state, count, head and rsp_valid
//  and loads the timer config reset values. Each result waits in the output
//  register; a full register stalls the walk. csr writes are always taken.
// -----------------------------------------------------------------------------
module reliable_packet_retransmit_table
   import rprt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [ID_BITS-1:0] req_packet_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_res,
   output logic [ID_BITS-1:0] rsp_result_id,
   output logic               rsp_resent,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [AGE_W-1:0]   age;
      logic [CD_W-1:0]    cd;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
      return (p == '0) ? LAST_IDX : p - 1'b1;
   endfunction

   entry_type entry_mem [ENTRIES];
   entry_type rdata_ff;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   w_ff, w_in;
   logic [IDX_W-1:0]   ptr_r_ff, ptr_r_in;
   logic [IDX_W-1:0]   ptr_w_ff, ptr_w_in;
   logic               matched_ff, matched_in;
   logic [1:0]         kind_ff, kind_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   event_type          final_ev_ff, final_ev_in;

   logic [FD_W-1:0]    first_delay_ff;
   logic [RI_W-1:0]    resend_interval_ff;
   logic [LIFE_W-1:0]  lifetime_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_event_ff, rsp_event_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic               rsp_resent_ff, rsp_resent_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic               out_free;
   logic [RI_W-1:0]    ieff;
   logic [AGE_W-1:0]   limit;
   logic [AGE_W-1:0]   age_up;
   logic               resend;
   logic [CD_W-1:0]    cd_new;
   logic               expire;
   logic               hit;
   logic               keep;
   logic               emit;
   logic               step;
   logic [CNT_W-1:0]   w_next;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign ieff      = (resend_interval_ff == '0) ? RI_W'(1) : resend_interval_ff;
   assign limit     = AGE_W'(first_delay_ff) + AGE_W'(lifetime_ff);

   assign age_up = (rdata_ff.age == AGE_MAX) ? rdata_ff.age : rdata_ff.age + 1'b1;
   assign resend = (rdata_ff.cd <= CD_W'(1));
   assign cd_new = resend ? CD_W'(ieff) : rdata_ff.cd - 1'b1;
   assign expire = (age_up >= limit);
   assign hit    = !matched_ff && (rdata_ff.id == id_ff);
   assign keep   = (kind_ff == REQ_TICK) ? !expire : !hit;
   assign emit   = (kind_ff == REQ_TICK) && (expire || resend);
   assign step   = (state_ff == ST_WALK) && (!emit || out_free);
   assign w_next = keep ? w_ff + 1'b1 : w_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      i_in          = i_ff;
      w_in          = w_ff;
      ptr_r_in      = ptr_r_ff;
      ptr_w_in      = ptr_w_ff;
      matched_in    = matched_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      final_ev_in   = final_ev_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_resent_in = rsp_resent_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_w_ff;
      wr_data       = rdata_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_type;
               id_in      = req_packet_id;
               i_in       = '0;
               w_in       = '0;
               matched_in = 1'b0;
               ptr_r_in   = head_ff;
               ptr_w_in   = head_ff;
               state_in   = ST_FINISH;
               case (req_type)
                  REQ_SEND: begin
                     if (count_ff == FULL_CNT) begin
                        final_ev_in = EV_FULL;
                     end else begin
                        final_ev_in = EV_STORED;
                        head_in     = ptr_dec(head_ff);
                        count_in    = count_ff + 1'b1;
                        wr_en       = 1'b1;
                        wr_addr     = ptr_dec(head_ff);
                        wr_data.id  = req_packet_id;
                        wr_data.age = '0;
                        wr_data.cd  = (first_delay_ff != '0) ? CD_W'(first_delay_ff)
                                                             : CD_W'(ieff);
                     end
                  end
                  REQ_DATA: begin
                     final_ev_in = EV_SEND_ACK;
                  end
                  REQ_ACK: begin
                     final_ev_in = EV_ACK_MISS;
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     final_ev_in = EV_TICK_DONE;
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = ST_WALK;
                     end
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (step) begin
               wr_en   = keep;
               wr_addr = ptr_w_ff;
               if (kind_ff == REQ_TICK) begin
                  wr_data.age = age_up;
                  wr_data.cd  = cd_new;
               end
               if (keep) begin
                  ptr_w_in = ptr_inc(ptr_w_ff);
               end
               w_in       = w_next;
               matched_in = matched_ff || ((kind_ff == REQ_ACK) && hit);
               i_in       = i_ff + 1'b1;
               ptr_r_in   = ptr_inc(ptr_r_ff);
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_event_in  = expire ? EV_EXPIRED : EV_RESEND;
                  rsp_id_in     = rdata_ff.id;
                  rsp_resent_in = expire && resend;
                  rsp_last_in   = 1'b0;
               end
               if ((i_ff + 1'b1) < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_inc(ptr_r_ff);
               end else begin
                  count_in = w_next;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_event_in  = (final_ev_ff == EV_ACK_MISS && matched_ff) ? EV_ACK_MATCH
                                                                         : final_ev_ff;
               rsp_id_in     = (final_ev_ff == EV_TICK_DONE) ? '0 : id_ff;
               rsp_resent_in = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= entry_mem[rd_addr];
      end
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         count_ff           <= '0;
         head_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
         first_delay_ff     <= FD_RESET;
         resend_interval_ff <= RI_RESET;
         lifetime_ff        <= LIFE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_FIRST_DELAY:     first_delay_ff     <= csr_wdata[FD_W-1:0];
               CSR_RESEND_INTERVAL: resend_interval_ff <= csr_wdata[RI_W-1:0];
               CSR_LIFETIME:        lifetime_ff        <= csr_wdata[LIFE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      w_ff          <= w_in;
      ptr_r_ff      <= ptr_r_in;
      ptr_w_ff      <= ptr_w_in;
      matched_ff    <= matched_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      final_ev_ff   <= final_ev_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_resent_ff <= rsp_resent_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_resent    = rsp_resent_ff;
   assign rsp_last      = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above table depth");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (w_ff <= i_ff) && (i_ff < count_ff))
      else $error("walk pointers out of order");

   a_tick_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EV_TICK_DONE) |-> rsp_last_ff && (rsp_id_ff == '0))
      else $error("tick done item malformed");

   a_resent_expired: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_resent_ff) |-> (rsp_event_ff == EV_EXPIRED) && !rsp_last_ff)
      else $error("resent flag on a non-expiry item");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (count_ff > $past(count_ff)) |-> ($past(state_ff) == ST_IDLE)
                                       && ($past(req_type) == REQ_SEND))
      else $error("table grew without a send");

endmodule

[verif/reliable_packet_retransmit_table_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// reliable_packet_retransmit_table_tb
// Self-checking bench for the retransmit table. A scoreboard class keeps its
// own copy of the table and timer registers, predicts the event items of
// every accepted request and checks the response stream in order. Stimulus
// is a short directed run followed by phases under different timer settings,
// with bursty requests, a stalling receiver and one long receiver hold.
// -----------------------------------------------------------------------------
module reliable_packet_retransmit_table_tb
   import rprt_pkg::*;
();

   localparam int          TABLE_SLOTS   = ENTRIES_DEF;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          REPORT_LIMIT  = 10;
   localparam logic [1:0]  CSR_SPARE     = 2'd3;

   logic               clock;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type      = REQ_DATA;
   logic [31:0]        req_packet_id = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [2:0]         rsp_event_res;
   logic [31:0]        rsp_result_id;
   logic               rsp_resent;
   logic               rsp_last;
   logic               csr_valid     = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index     = CSR_FIRST_DELAY;
   logic [CSR_W-1:0]   csr_wdata     = '0;

   logic               long_hold_go   = 1'b0;
   logic               long_hold_done = 1'b0;
   int                 hold_left      = 0;
   int                 mode_left      = 0;
   int                 stall_mode     = 0;

   typedef struct packed {
      event_type   ev;
      logic [31:0] id;
      logic        resent;
      logic        last;
   } table_event_type;

   class retransmit_scoreboard;
      logic [FD_W-1:0]   first_delay;
      logic [RI_W-1:0]   resend_interval;
      logic [LIFE_W-1:0] lifetime;
      int                live_count;
      logic [31:0]       slot_id        [TABLE_SLOTS];
      logic [AGE_W-1:0]  slot_age       [TABLE_SLOTS];
      logic [CD_W-1:0]   slot_countdown [TABLE_SLOTS];
      table_event_type   expected_events[$];
      int                mismatch_count;

      function new();
         first_delay     = FD_RESET;
         resend_interval = RI_RESET;
         lifetime        = LIFE_RESET;
         live_count      = 0;
         mismatch_count  = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_FIRST_DELAY:     first_delay     = data[FD_W-1:0];
            CSR_RESEND_INTERVAL: resend_interval = data[RI_W-1:0];
            CSR_LIFETIME:        lifetime        = data[LIFE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CD_W-1:0] resend_period();
         return (resend_interval == 0) ? CD_W'(1) : resend_interval;
      endfunction

      function void expect_event(event_type ev, logic [31:0] id, logic resent);
         table_event_type e;
         e.ev     = ev;
         e.id     = id;
         e.resent = resent;
         e.last   = 1'b0;
         expected_events.push_back(e);
      endfunction

      function void drop_slot(int k);
         for (int j = k; j + 1 < live_count; j++) begin
            slot_id[j]        = slot_id[j + 1];
            slot_age[j]       = slot_age[j + 1];
            slot_countdown[j] = slot_countdown[j + 1];
         end
         live_count--;
      endfunction

      // ack targets mostly live ids; sends sometimes duplicate one
      function logic [31:0] pick_id(req_kind_type kind);
         if (live_count > 0) begin
            if ((kind == REQ_ACK && $urandom_range(0, 99) < 65) ||
                (kind == REQ_SEND && $urandom_range(0, 9) < 2))
               return slot_id[$urandom_range(0, live_count - 1)];
         end
         return $urandom;
      endfunction

      function void accept_request(req_kind_type kind, logic [31:0] id);
         int              i;
         logic            resend;
         logic [31:0]     eid;
         table_event_type tail;
         case (kind)
            REQ_SEND: begin
               if (live_count >= TABLE_SLOTS) begin
                  expect_event(EV_FULL, id, 1'b0);
               end else begin
                  for (i = live_count; i > 0; i--) begin
                     slot_id[i]        = slot_id[i - 1];
                     slot_age[i]       = slot_age[i - 1];
                     slot_countdown[i] = slot_countdown[i - 1];
                  end
                  live_count++;
                  slot_id[0]        = id;
                  slot_age[0]       = '0;
                  slot_countdown[0] = (first_delay != 0) ? first_delay : resend_period();
                  expect_event(EV_STORED, id, 1'b0);
               end
            end
            REQ_ACK: begin
               for (i = 0; i < live_count; i++)
                  if (slot_id[i] == id) break;
               if (i < live_count) begin
                  drop_slot(i);
                  expect_event(EV_ACK_MATCH, id, 1'b0);
               end else begin
                  expect_event(EV_ACK_MISS, id, 1'b0);
               end
            end
            REQ_DATA: expect_event(EV_SEND_ACK, id, 1'b0);
            default: begin
               i = 0;
               while (i < live_count) begin
                  eid    = slot_id[i];
                  resend = 1'b0;
                  if (slot_age[i] != AGE_MAX) slot_age[i]++;
                  if (slot_countdown[i] <= 1) begin
                     resend            = 1'b1;
                     slot_countdown[i] = resend_period();
                  end else begin
                     slot_countdown[i]--;
                  end
                  if (int'(slot_age[i]) >= int'(first_delay) + int'(lifetime)) begin
                     expect_event(EV_EXPIRED, eid, resend);
                     drop_slot(i);
                  end else begin
                     if (resend) expect_event(EV_RESEND, eid, 1'b0);
                     i++;
                  end
               end
               expect_event(EV_TICK_DONE, '0, 1'b0);
            end
         endcase
         tail      = expected_events.pop_back();
         tail.last = 1'b1;
         expected_events.push_back(tail);
      endfunction

      function void check_event(logic [2:0] ev, logic [31:0] id, logic resent, logic last);
         table_event_type want;
         if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected item: ev=%0d id=%h resent=%0d last=%0d",
                        ev, id, resent, last);
            return;
         end
         want = expected_events.pop_front();
         if (ev !== want.ev || id !== want.id || resent !== want.resent ||
             last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"mismatch: expected ev=%0d id=%h resent=%0d last=%0d,",
                         " got ev=%0d id=%h resent=%0d last=%0d"},
                        want.ev, want.id, want.resent, want.last,
                        ev, id, resent, last);
         end
      endfunction
   endclass

   retransmit_scoreboard sb = new();

   reliable_packet_retransmit_table dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_packet_id (req_packet_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_result_id (rsp_result_id),
      .rsp_resent    (rsp_resent),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // receiver: random stall modes, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_go && !long_hold_done) begin
         rsp_ready      <= 1'b0;
         hold_left      <= HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 96);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_event(rsp_event_res, rsp_result_id, rsp_resent, rsp_last);
   end

   // leaves req_valid high; caller lowers it for a gap
   task automatic send_item(req_kind_type kind, logic [31:0] id);
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_packet_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.accept_request(kind, id);
   endtask

   task automatic csr_put(logic [1:0] idx, logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic settle();
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_kind_type pick_kind(int send_w, int ack_w, int data_w);
      int r;
      r = $urandom_range(0, 99);
      if (r < send_w) return REQ_SEND;
      if (r < send_w + ack_w) return REQ_ACK;
      if (r < send_w + ack_w + data_w) return REQ_DATA;
      return REQ_TICK;
   endfunction

   task automatic run_phase(int fd, int ri, int life, int items, int send_w,
                            int ack_w, int data_w, bit with_hold, bit poke_spare);
      int           burst;
      req_kind_type kind;
      logic [31:0]  id;
      settle();
      csr_put(CSR_FIRST_DELAY, CSR_W'(fd));
      csr_put(CSR_RESEND_INTERVAL, CSR_W'(ri));
      csr_put(CSR_LIFETIME, CSR_W'(life));
      if (poke_spare) csr_put(CSR_SPARE, CSR_W'($urandom));
      csr_valid <= 1'b0;
      if (with_hold) long_hold_go <= 1'b1;
      burst = $urandom_range(1, 16);
      for (int n = 0; n < items; n++) begin
         kind = pick_kind(send_w, ack_w, data_w);
         id   = sb.pick_id(kind);
         send_item(kind, id);
         if (burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst = ($urandom_range(0, 9) < 3) ? 40 : $urandom_range(1, 16);
         end else begin
            burst--;
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed run under reset timer values
      send_item(REQ_SEND, 32'h0000_0000);
      send_item(REQ_SEND, 32'hFFFF_FFFF);
      send_item(REQ_SEND, 32'h1234_5678);
      send_item(REQ_SEND, 32'h0000_0000);
      send_item(REQ_DATA, 32'h0000_0000);
      send_item(REQ_DATA, 32'hFFFF_FFFF);
      send_item(REQ_ACK,  32'h0000_0000);
      send_item(REQ_ACK,  32'hDEAD_BEEF);
      repeat (6) send_item(REQ_TICK, 32'hFFFF_FFFF);
      send_item(REQ_ACK,  32'hFFFF_FFFF);
      send_item(REQ_ACK,  32'h1234_5678);
      send_item(REQ_ACK,  32'h0000_0000);
      send_item(REQ_ACK,  32'h0000_0000);
      send_item(REQ_TICK, 32'h0000_0000);
      req_valid <= 1'b0;

      run_phase(0, 1, 1, 50, 40, 20, 10, 1'b0, 1'b0);
      run_phase(2, 0, 3, 50, 35, 25, 10, 1'b0, 1'b1);
      run_phase(1, 3, 0, 45, 40, 20, 10, 1'b0, 1'b0);
      run_phase(4095, 4095, 4095, 60, 85, 5, 5, 1'b0, 1'b0);
      run_phase(4, 2, 20, 70, 35, 20, 10, 1'b1, 1'b0);
      run_phase(0, 0, 0, 45, 40, 20, 10, 1'b0, 1'b1);
      run_phase($urandom_range(0, 15), $urandom_range(0, 8), $urandom_range(0, 40),
                70, 35, 25, 10, 1'b0, 1'b0);
      run_phase(int'(FD_RESET), int'(RI_RESET), int'(LIFE_RESET),
                70, 40, 20, 10, 1'b0, 1'b0);
      settle();

      if (sb.mismatch_count == 0 && sb.expected_events.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
